>>> hw/rtl/lcar_pkg.sv
// shared types, constants and register map of the load cell reader
`default_nettype none

package lcar_pkg;

    // default converter word width
    localparam int SAMPLE_BITS_DEFAULT = 24;

    // field widths
    localparam int AVG_W = 8;
    localparam int RAW_W = 24;
    localparam int CPG_W = 31;
    localparam int MG_W  = 35;

    // configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_AVG_COUNT       = 2'd0;
    localparam logic [1:0] REG_ZERO_OFFSET     = 2'd1;
    localparam logic [1:0] REG_COUNTS_PER_GRAM = 2'd2;

    // register reset values
    localparam logic [AVG_W-1:0] AVG_COUNT_RST       = 8'd1;
    localparam logic [RAW_W-1:0] ZERO_OFFSET_RST     = 24'h80_0000;
    localparam logic [CPG_W-1:0] COUNTS_PER_GRAM_RST = 31'd1;

    // milligram scale
    localparam int MG_SCALE = 1000;
    localparam int MG_SCALE_W = 10;

    typedef struct packed {
        logic [AVG_W-1:0] avg_count;
        logic [RAW_W-1:0] zero_offset;
        logic [CPG_W-1:0] counts_per_gram;
    } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/lcar_cfg.sv
// configuration register file behind the apb-style port
`default_nettype none

module lcar_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lcar_pkg::APB_AW-1:0] paddr,
    input  wire logic [lcar_pkg::APB_DW-1:0] pwdata,
    output logic      [lcar_pkg::APB_DW-1:0] prdata,
    output logic                             pready,
    output lcar_pkg::cfg_t                   cfg
);

    lcar_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.avg_count       <= lcar_pkg::AVG_COUNT_RST;
            cfg_reg.zero_offset     <= lcar_pkg::ZERO_OFFSET_RST;
            cfg_reg.counts_per_gram <= lcar_pkg::COUNTS_PER_GRAM_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                lcar_pkg::REG_AVG_COUNT:
                    cfg_reg.avg_count <= pwdata[lcar_pkg::AVG_W-1:0];
                lcar_pkg::REG_ZERO_OFFSET:
                    cfg_reg.zero_offset <= pwdata[lcar_pkg::RAW_W-1:0];
                lcar_pkg::REG_COUNTS_PER_GRAM:
                    cfg_reg.counts_per_gram <= pwdata[lcar_pkg::CPG_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            lcar_pkg::REG_AVG_COUNT:
                prdata = lcar_pkg::APB_DW'(cfg_reg.avg_count);
            lcar_pkg::REG_ZERO_OFFSET:
                prdata = lcar_pkg::APB_DW'(cfg_reg.zero_offset);
            lcar_pkg::REG_COUNTS_PER_GRAM:
                prdata = lcar_pkg::APB_DW'(cfg_reg.counts_per_gram);
            default:
                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/lcar_div.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module lcar_div #(
    parameter int N_W = 34,
    parameter int D_W = 31
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [N_W-1:0] dividend,
    input  wire logic [D_W-1:0] divisor,
    output logic                done,
    output logic      [N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(N_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   dvs_reg;
    logic [N_W-1:0]   quo_reg;

    logic [D_W:0]     trial;
    logic             fits;
    logic [D_W:0]     diff;

    assign trial = {rem_reg, quo_reg[N_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
            cnt_reg <= CNT_W'(N_W - 1);
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
            quo_reg <= {quo_reg[N_W-2:0], fits};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // partial remainder stays below the divisor
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < dvs_reg))
        else $error("divider remainder not below divisor");

    // no restart while a division runs
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    // completion is a single-cycle pulse
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");

endmodule

`default_nettype wire

>>> hw/rtl/load_cell_adc_reader_averaging_unit.sv
// top level of the load cell converter reader with averaging
// usage:
// - each input transaction is one half-period tick of the converter serial
//   clock, carrying start_req and the sampled dout_level
// - each input transaction gives exactly one output transaction with the
//   serial clock level, busy flag and, on completion, the averaged reading
//   and the weight in milligrams
// - registers avg_count, zero_offset and counts_per_gram sit on the apb port
//   at byte addresses 0, 4 and 8; pready is always high
// tick flow:
// - an ordinary tick is worked out at acceptance; its result sits in the
//   output register in the next cycle, and the next tick is taken at once
//   unless the output stalls
// - the tick that completes a measurement makes two passes through the
//   shared one-bit-per-cycle divider (sum/count, then
//   difference*1000/counts_per_gram); in_stall is high meanwhile
// reset clears the tick state machine, the sequencer and output valid
// a stalled output holds its result; a new tick is then taken only at the
// edge where the held result leaves
`default_nettype none

module load_cell_adc_reader_averaging_unit #(
    parameter int SAMPLE_BITS = lcar_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic        [lcar_pkg::APB_AW-1:0] paddr,
    input  wire logic        [lcar_pkg::APB_DW-1:0] pwdata,
    output logic             [lcar_pkg::APB_DW-1:0] prdata,
    output logic                                    pready,
    // tick channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               start_req,
    input  wire logic                               dout_level,
    // result channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    sck_level,
    output logic                                    done_res,
    output logic             [lcar_pkg::RAW_W-1:0]  raw_average,
    output logic signed      [lcar_pkg::MG_W-1:0]   milligrams,
    output logic                                    busy_res
);

    // widths derived from the word size
    localparam int SUM_W  = SAMPLE_BITS + lcar_pkg::AVG_W;
    localparam int AW     = (SAMPLE_BITS > lcar_pkg::RAW_W) ? SAMPLE_BITS : lcar_pkg::RAW_W;
    localparam int PROD_W = AW + lcar_pkg::MG_SCALE_W;
    localparam int EXT_W  = (PROD_W > lcar_pkg::MG_W) ? PROD_W : lcar_pkg::MG_W;
    localparam int BC_W   = $clog2(SAMPLE_BITS + 1);

    // converter protocol phase, one step per tick
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT,
        PH_SHIFT,
        PH_PULSE,
        PH_PULSE_END
    } phase_t;

    // arithmetic sequencer for the completing tick
    typedef enum logic [2:0] {
        SQ_TICK,
        SQ_AVG,
        SQ_MUL,
        SQ_MG_GO,
        SQ_MG
    } seq_t;

    lcar_pkg::cfg_t cfg;

    // tick state
    phase_t                  phase_reg, phase_next;
    logic [BC_W-1:0]         bit_cnt_reg, bit_cnt_next;
    logic [SAMPLE_BITS-1:0]  shift_reg, shift_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [lcar_pkg::AVG_W-1:0] taken_reg, taken_next;
    logic                    clk_high_reg, clk_high_next;

    // sequencer and datapath
    seq_t                    seq_reg, seq_next;
    logic [AW-1:0]           avg_reg, avg_next;
    logic [AW-1:0]           mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic                    sck_reg, sck_next;
    logic                    done_reg, done_next;
    logic [lcar_pkg::RAW_W-1:0] raw_reg, raw_next;
    logic [lcar_pkg::MG_W-1:0]  mg_reg, mg_next;
    logic                    busy_reg, busy_next;

    // divider hookup
    logic                    div_start;
    logic [PROD_W-1:0]       div_dividend;
    logic [lcar_pkg::CPG_W-1:0] div_divisor;
    logic                    div_done;
    logic [PROD_W-1:0]       div_quo;

    logic                    accept;
    logic                    out_free;

    lcar_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lcar_div #(
        .N_W (PROD_W),
        .D_W (lcar_pkg::CPG_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // output register empties or is taken this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (seq_reg != SQ_TICK) || !out_free;
    assign accept   = in_valid && !in_stall;

    assign out_valid   = out_valid_reg;
    assign sck_level   = sck_reg;
    assign done_res    = done_reg;
    assign raw_average = raw_reg;
    assign milligrams  = $signed(mg_reg);
    assign busy_res    = busy_reg;

    always_comb
    begin
        logic [lcar_pkg::AVG_W-1:0] n_cnt;
        logic [lcar_pkg::CPG_W-1:0] cpg;
        logic [SAMPLE_BITS-1:0]     raw_word;
        logic                       final_tick;
        logic signed [AW:0]         diff;
        logic [EXT_W-1:0]           q_ext;
        logic [EXT_W-1:0]           mg_full;

        // defaults: hold
        phase_next     = phase_reg;
        bit_cnt_next   = bit_cnt_reg;
        shift_next     = shift_reg;
        sum_next       = sum_reg;
        taken_next     = taken_reg;
        clk_high_next  = clk_high_reg;
        seq_next       = seq_reg;
        avg_next       = avg_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && out_stall;
        sck_next       = sck_reg;
        done_next      = done_reg;
        raw_next       = raw_reg;
        mg_next        = mg_reg;
        busy_next      = busy_reg;
        div_start      = 1'b0;
        div_dividend   = PROD_W'(sum_next);
        div_divisor    = '0;
        final_tick     = 1'b0;

        // zero count or divisor act as one
        n_cnt    = (cfg.avg_count == '0) ? lcar_pkg::AVG_W'(1) : cfg.avg_count;
        cpg      = (cfg.counts_per_gram == '0) ? lcar_pkg::CPG_W'(1) : cfg.counts_per_gram;
        // offset binary: invert the sign bit
        raw_word = {~shift_reg[SAMPLE_BITS-1], shift_reg[SAMPLE_BITS-2:0]};
        diff     = '0;
        q_ext    = EXT_W'(div_quo);
        mg_full  = neg_reg ? (~q_ext + 1'b1) : q_ext;

        case (seq_reg)
            SQ_TICK:
            begin
                if (accept)
                begin
                    sck_next = 1'b0;
                    case (phase_reg)
                        PH_IDLE:
                        begin
                            if (start_req)
                            begin
                                sum_next   = '0;
                                taken_next = '0;
                                phase_next = PH_WAIT;
                            end
                        end
                        PH_WAIT:
                        begin
                            // converter signals data ready by pulling dout low
                            if (!dout_level)
                            begin
                                shift_next    = '0;
                                bit_cnt_next  = '0;
                                clk_high_next = 1'b1;
                                sck_next      = 1'b1;
                                phase_next    = PH_SHIFT;
                            end
                        end
                        PH_SHIFT:
                        begin
                            if (clk_high_reg)
                            begin
                                // falling edge: take the bit
                                shift_next    = {shift_reg[SAMPLE_BITS-2:0], dout_level};
                                bit_cnt_next  = bit_cnt_reg + 1'b1;
                                clk_high_next = 1'b0;
                                if (bit_cnt_next >= BC_W'(SAMPLE_BITS))
                                begin
                                    phase_next = PH_PULSE;
                                end
                            end
                            else
                            begin
                                clk_high_next = 1'b1;
                                sck_next      = 1'b1;
                            end
                        end
                        PH_PULSE:
                        begin
                            // extra pulse selects the next conversion
                            clk_high_next = 1'b1;
                            sck_next      = 1'b1;
                            phase_next    = PH_PULSE_END;
                        end
                        default:
                        begin
                            clk_high_next = 1'b0;
                            sum_next      = sum_reg + SUM_W'(raw_word);
                            taken_next    = taken_reg + 1'b1;
                            if (taken_next >= n_cnt)
                            begin
                                final_tick = 1'b1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_WAIT;
                            end
                        end
                    endcase

                    if (final_tick)
                    begin
                        // average first, result leaves after the arithmetic
                        div_start    = 1'b1;
                        div_dividend = PROD_W'(sum_next);
                        div_divisor  = lcar_pkg::CPG_W'(n_cnt);
                        done_next    = 1'b1;
                        busy_next    = 1'b0;
                        seq_next     = SQ_AVG;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        done_next      = 1'b0;
                        raw_next       = '0;
                        mg_next        = '0;
                        busy_next      = (phase_next != PH_IDLE);
                    end
                end
            end
            SQ_AVG:
            begin
                if (div_done)
                begin
                    avg_next = AW'(div_quo[SAMPLE_BITS-1:0]);
                    diff     = $signed({1'b0, AW'(div_quo[SAMPLE_BITS-1:0])})
                             - $signed((AW + 1)'(cfg.zero_offset));
                    neg_next = diff[AW];
                    mag_next = diff[AW] ? AW'(-diff) : diff[AW-1:0];
                    seq_next = SQ_MUL;
                end
            end
            SQ_MUL:
            begin
                prod_next = PROD_W'(mag_reg) * PROD_W'(lcar_pkg::MG_SCALE);
                seq_next  = SQ_MG_GO;
            end
            SQ_MG_GO:
            begin
                div_start    = 1'b1;
                div_dividend = prod_reg;
                div_divisor  = cpg;
                seq_next     = SQ_MG;
            end
            default:
            begin
                if (div_done)
                begin
                    // magnitude quotient with sign restored truncates toward zero
                    raw_next       = avg_reg[lcar_pkg::RAW_W-1:0];
                    mg_next        = mg_full[lcar_pkg::MG_W-1:0];
                    out_valid_next = 1'b1;
                    seq_next       = SQ_TICK;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_cnt_reg   <= '0;
            shift_reg     <= '0;
            sum_reg       <= '0;
            taken_reg     <= '0;
            clk_high_reg  <= 1'b0;
            seq_reg       <= SQ_TICK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            bit_cnt_reg   <= bit_cnt_next;
            shift_reg     <= shift_next;
            sum_reg       <= sum_next;
            taken_reg     <= taken_next;
            clk_high_reg  <= clk_high_next;
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath and output payload, no reset needed
    always_ff @(posedge clk)
    begin
        avg_reg  <= avg_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        sck_reg  <= sck_next;
        done_reg <= done_next;
        raw_reg  <= raw_next;
        mg_reg   <= mg_next;
        busy_reg <= busy_next;
    end

    // the divider only reports back while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (seq_reg == SQ_AVG || seq_reg == SQ_MG))
        else $error("divider finished outside a wait state");

    // the output register is empty while the arithmetic runs
    a_out_empty_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg != SQ_TICK) |-> !out_valid_reg)
        else $error("result pending during measurement arithmetic");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=>
            (out_valid_reg && $stable({sck_reg, done_reg, raw_reg, mg_reg, busy_reg})))
        else $error("stalled result changed");

endmodule

`default_nettype wire

>>> tb/load_cell_reader_checker.sv
// checker for the load cell reader: watches both channels, predicts every tick and compares
module load_cell_reader_checker
    import lcar_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_AW-1:0]       paddr,
    input  logic [APB_DW-1:0]       pwdata,
    input  logic                    pready,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic                    start_req,
    input  logic                    dout_level,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic                    sck_level,
    input  logic                    done_res,
    input  logic [RAW_W-1:0]        raw_average,
    input  logic signed [MG_W-1:0]  milligrams,
    input  logic                    busy_res,
    output int                      failures,
    output int                      pending,
    output logic                    reader_idle
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_W = SAMPLE_BITS_DEFAULT;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT,
        PH_SHIFT,
        PH_PULSE,
        PH_PULSE_END
    } reader_phase_e;

    typedef struct packed {
        logic             sck;
        logic             done;
        logic [RAW_W-1:0] raw;
        logic [MG_W-1:0]  mg;
        logic             busy;
    } tick_result_t;

    cfg_t              cfg;
    reader_phase_e     phase;
    logic [5:0]        bits_in;
    logic [WORD_W-1:0] shift_word;
    logic [63:0]       reading_sum;
    logic [7:0]        readings_taken;
    logic              sck_high;
    tick_result_t      pending_tick_results[$];

    // advances the reader by one half-period tick and returns what it drives
    function automatic tick_result_t predict_tick_result(logic start, logic dout);
        tick_result_t      r;
        logic [WORD_W-1:0] reading;
        logic [63:0]       count;
        logic [63:0]       divisor;
        logic [63:0]       average;
        longint            diff;
        longint            weight;
        r = '0;
        case (phase)
            PH_IDLE:
                if (start)
                begin
                    reading_sum = '0;
                    readings_taken = '0;
                    phase = PH_WAIT;
                end
            PH_WAIT:
                if (!dout)
                begin
                    shift_word = '0;
                    bits_in = '0;
                    sck_high = 1'b1;
                    r.sck = 1'b1;
                    phase = PH_SHIFT;
                end
            PH_SHIFT:
                if (sck_high)
                begin
                    // falling edge of sck takes the data line
                    shift_word = {shift_word[WORD_W-2:0], dout};
                    bits_in++;
                    sck_high = 1'b0;
                    if (bits_in >= WORD_W)
                        phase = PH_PULSE;
                end
                else
                begin
                    sck_high = 1'b1;
                    r.sck = 1'b1;
                end
            PH_PULSE:
            begin
                sck_high = 1'b1;
                r.sck = 1'b1;
                phase = PH_PULSE_END;
            end
            default:
            begin
                reading = shift_word ^ {1'b1, {(WORD_W-1){1'b0}}};
                count = (cfg.avg_count == '0) ? 64'd1 : 64'(cfg.avg_count);
                sck_high = 1'b0;
                reading_sum += 64'(reading);
                readings_taken++;
                if (64'(readings_taken) >= count)
                begin
                    average = reading_sum / count;
                    divisor = (cfg.counts_per_gram == '0) ? 64'd1 : 64'(cfg.counts_per_gram);
                    diff = longint'(average) - longint'(cfg.zero_offset);
                    weight = (diff * MG_SCALE) / longint'(divisor);
                    r.done = 1'b1;
                    r.raw = average[RAW_W-1:0];
                    r.mg = weight[MG_W-1:0];
                    phase = PH_IDLE;
                end
                else
                    phase = PH_WAIT;
            end
        endcase
        r.busy = (phase != PH_IDLE);
        return r;
    endfunction

    task automatic compare_field(string name, longint expected_val, longint actual_val);
        if (expected_val != actual_val)
        begin
            $error("%s: expected %0d, actual %0d", name, expected_val, actual_val);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        tick_result_t want;
        if (!rst_n)
        begin
            cfg = '{AVG_COUNT_RST, ZERO_OFFSET_RST, COUNTS_PER_GRAM_RST};
            phase = PH_IDLE;
            bits_in = '0;
            shift_word = '0;
            reading_sum = '0;
            readings_taken = '0;
            sck_high = 1'b0;
            pending_tick_results.delete();
            failures = 0;
            pending <= 0;
            reader_idle <= 1'b1;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_tick_results.size() == 0)
                begin
                    $error("result transaction with no tick waiting for it");
                    failures++;
                end
                else
                begin
                    want = pending_tick_results.pop_front();
                    compare_field("sck_level", want.sck, sck_level);
                    compare_field("done_res", want.done, done_res);
                    compare_field("raw_average", want.raw, raw_average);
                    compare_field("milligrams", $signed(want.mg), milligrams);
                    compare_field("busy_res", want.busy, busy_res);
                end
            end
            if (in_valid && !in_stall)
                pending_tick_results.push_back(predict_tick_result(start_req, dout_level));
            if (psel && penable && pwrite && pready)
                case (paddr[3:2])
                    REG_AVG_COUNT:       cfg.avg_count = pwdata[AVG_W-1:0];
                    REG_ZERO_OFFSET:     cfg.zero_offset = pwdata[RAW_W-1:0];
                    REG_COUNTS_PER_GRAM: cfg.counts_per_gram = pwdata[CPG_W-1:0];
                    default:             ;
                endcase
            pending <= pending_tick_results.size();
            reader_idle <= (phase == PH_IDLE);
        end
    end

endmodule

>>> tb/load_cell_adc_reader_averaging_unit_test.sv
// testbench top of the load cell reader: stimulus, receiver stalls and verdict
module load_cell_adc_reader_averaging_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lcar_pkg::*;

    localparam int WORD_W       = SAMPLE_BITS_DEFAULT;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_TICKS = 280;
    localparam int RANDOM_SETS  = 4;
    localparam int HOLD_CYCLES  = 300;
    // a completing tick keeps the divider busy for two passes
    localparam int TAIL_CYCLES  = 100;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    // configuration port
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_AW-1:0]      paddr = '0;
    logic [APB_DW-1:0]      pwdata = '0;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    // tick channel
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   start_req = 1'b0;
    logic                   dout_level = 1'b0;

    // result channel
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   sck_level;
    logic                   done_res;
    logic [RAW_W-1:0]       raw_average;
    logic signed [MG_W-1:0] milligrams;
    logic                   busy_res;

    // from the checker
    int                     failures;
    int                     pending;
    logic                   reader_idle;

    // quiet turns off idling on both sides; hold_armed asks for one long receiver hold-off
    logic                   quiet = 1'b0;
    logic                   hold_armed = 1'b0;
    logic                   hold_done = 1'b0;
    int                     hold_count = 0;

    int                     cycle_count = 0;
    int                     ticks_sent = 0;
    // tick count at the start of the current random set
    int                     set_start = 0;
    // avg_count as last written, so each measurement feeds the right number of words
    logic [AVG_W-1:0]       avg_setting = AVG_COUNT_RST;

    load_cell_adc_reader_averaging_unit DUT (.*);

    load_cell_reader_checker result_check (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: random stalls, none while quiet, and one long hold-off that lets the block fill up
    always @(posedge clk)
    begin
        if (hold_armed && !hold_done)
        begin
            out_stall <= 1'b1;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES)
                hold_done <= 1'b1;
        end
        else
            out_stall <= !quiet && ($urandom_range(99) < 15);
    end

    function automatic logic random_bit();
        return 1'($urandom_range(1));
    endfunction

    // converter words lean on the ends of the range and the sign flip point
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return {1'b1, {(WORD_W-1){1'b0}}};
            3:       return {1'b0, {(WORD_W-1){1'b1}}};
            default: return WORD_W'($urandom);
        endcase
    endfunction

    // mostly short averages keep the run fast; zero must behave as one
    function automatic logic [AVG_W-1:0] random_avg();
        case ($urandom_range(9))
            0:          return '0;
            1, 2, 3, 4: return AVG_W'(1);
            5, 6:       return AVG_W'($urandom_range(2, 4));
            7:          return AVG_W'($urandom_range(5, 8));
            default:    return AVG_W'(2);
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] random_offset();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    // zero divisor must behave as one; full width forces weights toward zero
    function automatic logic [CPG_W-1:0] random_divisor();
        case ($urandom_range(4))
            0:       return '0;
            1:       return CPG_W'($urandom);
            2:       return CPG_W'($urandom_range(1, 10));
            default: return CPG_W'($urandom_range(1, 3000));
        endcase
    endfunction

    // one transaction on the tick channel, with random idle cycles in front of it
    task automatic send_tick(logic start, logic dout);
        if (!quiet)
            while ($urandom_range(99) < 15)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        start_req <= start;
        dout_level <= dout;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ticks_sent++;
    endtask

    // one conversion as the converter would answer it: data line high for a while,
    // then low, then one bit per falling sck edge and the extra gain pulse;
    // start_req is random throughout and must be ignored while busy
    task automatic shift_word_in(logic [WORD_W-1:0] word);
        repeat ($urandom_range(0, 3))
            send_tick(random_bit(), 1'b1);
        send_tick(random_bit(), 1'b0);
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            send_tick(random_bit(), word[i]);
            // rising sck tick: the data line is not looked at
            if (i != 0)
                send_tick(random_bit(), random_bit());
        end
        send_tick(random_bit(), random_bit());
        send_tick(random_bit(), random_bit());
    endtask

    // a full averaged measurement, starting from idle
    task automatic measure(logic use_fixed, logic [WORD_W-1:0] fixed_word);
        int readings;
        readings = (avg_setting == '0) ? 1 : int'(avg_setting);
        send_tick(1'b1, random_bit());
        repeat (readings)
            shift_word_in(use_fixed ? fixed_word : pick_word());
    endtask

    // after arbitrary ticks, step the reader until it is back at idle;
    // in_valid drops after each tick so the checker's idle flag is up to date
    task automatic drain_reader();
        in_valid <= 1'b0;
        @(posedge clk);
        while (!reader_idle)
        begin
            send_tick(1'b0, 1'($urandom_range(3) == 0));
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // sender pauses until the reader is idle and every result has come back
    task automatic wait_until_settled();
        drain_reader();
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [APB_DW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(logic [AVG_W-1:0] avg, logic [RAW_W-1:0] offset,
                             logic [CPG_W-1:0] divisor);
        wait_until_settled();
        write_register(REG_AVG_COUNT, APB_DW'(avg));
        write_register(REG_ZERO_OFFSET, APB_DW'(offset));
        write_register(REG_COUNTS_PER_GRAM, APB_DW'(divisor));
        avg_setting = avg;
    endtask

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("load_cell_adc_reader_averaging_unit_test NOT OK");
        $finish;
    end

    initial
    begin
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero at mid scale, one count per gram
        measure(1'b1, '0);
        measure(1'b1, '1);
        // start low at idle: nothing starts
        repeat (3)
            send_tick(1'b0, random_bit());

        // zero average count and zero divisor both fall back to one;
        // full scale against a zero offset gives the largest weight
        configure('0, '0, '0);
        measure(1'b1, {1'b0, {(WORD_W-1){1'b1}}});

        // bottom of scale against a full scale offset: most negative weight
        configure(AVG_W'(1), '1, CPG_W'(1));
        measure(1'b1, {1'b1, {(WORD_W-1){1'b0}}});

        // largest divisor truncates toward zero
        configure(AVG_W'(2), '1, '1);
        measure(1'b1, {1'b1, {(WORD_W-1){1'b0}}});

        // odd divisor, negative weights truncate toward zero too
        configure(AVG_W'(1), RAW_W'($urandom), CPG_W'(7));
        measure(1'b0, '0);

        // random part: several settings, mostly well formed measurements with random
        // words, the rest random ticks; long hold-off in one set, no idling in another
        ticks_sent = 0;
        for (int set_idx = 0; set_idx < RANDOM_SETS; set_idx++)
        begin
            configure(random_avg(), random_offset(), random_divisor());
            quiet <= (set_idx == 3);
            if (set_idx == 2)
                hold_armed <= 1'b1;
            set_start = ticks_sent;
            while (ticks_sent - set_start < RANDOM_TICKS / RANDOM_SETS)
            begin
                if ($urandom_range(99) < 85)
                    measure(1'b0, '0);
                else
                begin
                    repeat ($urandom_range(1, 40))
                        send_tick(random_bit(), random_bit());
                    drain_reader();
                end
            end
        end

        quiet <= 1'b0;
        wait_until_settled();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("load_cell_adc_reader_averaging_unit_test OK");
        else
            $display("load_cell_adc_reader_averaging_unit_test NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/lcar_pkg.sv
hw/rtl/lcar_cfg.sv
hw/rtl/lcar_div.sv
hw/rtl/load_cell_adc_reader_averaging_unit.sv
tb/load_cell_reader_checker.sv
tb/load_cell_adc_reader_averaging_unit_test.sv
